@@ src/bdlp_pkg.sv @@
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the two-button debouncer with long press.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    // default timestamp width and register reset values
    localparam int unsigned TIME_BITS_DEF = 32;
    localparam int unsigned CFG_IDX_BITS  = 8;

    localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd50;
    localparam logic [31:0] LONG_PRESS_MS_RST = 32'd5000;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_MS   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS_MS = CFG_IDX_BITS'(1);

    // input beat
    typedef struct packed {
        logic [31:0] now_ms;
        logic        enter_level;
        logic        back_level;
        logic        take_enter;
        logic        take_short;
        logic        take_long;
    } bdlp_in_t;

    // result beat
    typedef struct packed {
        logic enter_pending;
        logic short_pending;
        logic long_pending;
        logic enter_stable_level;
        logic back_stable_level;
    } bdlp_out_t;

    // debouncer status toward the event logic
    typedef struct packed {
        logic stable;   // debounced level after this update
        logic change;   // debounced level changed in this update
    } bdlp_dbnc_t;

endpackage

@@ src/bdlp_debounce.sv @@
// ----------------------------------------------------------------------------
// bdlp_debounce
// Debouncer for one active-low button: stable level follows the raw level
// once the raw level has held for longer than the debounce time.
// ----------------------------------------------------------------------------
module bdlp_debounce
    import bdlp_pkg::*;
#(
    parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 raw,
    input  logic [TIME_BITS-1:0] now,
    input  logic [15:0]          debounce_ms,
    output bdlp_dbnc_t           status
);

    logic                 raw_prev_reg;
    logic                 stable_reg;
    logic [TIME_BITS-1:0] change_time_reg;

    logic                 raw_changed;
    logic [TIME_BITS-1:0] elapsed;
    logic                 settle;
    logic                 stable_next;

    // elapsed time since the last raw change, zero when it changes now
    always_comb begin
        raw_changed = (raw != raw_prev_reg);
        elapsed     = raw_changed ? '0 : (now - change_time_reg);
        settle      = (elapsed > TIME_BITS'(debounce_ms)) && (raw != stable_reg);
        stable_next = settle ? raw : stable_reg;
    end

    // status order: stable, change
    assign status = {stable_next, settle};

    // state update once per beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_prev_reg    <= 1'b1;
            stable_reg      <= 1'b1;
            change_time_reg <= '0;
        end else if (en) begin
            raw_prev_reg <= raw;
            stable_reg   <= stable_next;
            if (raw_changed) begin
                change_time_reg <= now;
            end
        end
    end

endmodule

@@ src/bdlp_events.sv @@
// ----------------------------------------------------------------------------
// bdlp_events
// Press, short-press and long-press event flags with acknowledge clearing.
// ----------------------------------------------------------------------------
module bdlp_events
    import bdlp_pkg::*;
#(
    parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic [TIME_BITS-1:0] now,
    input  logic                 take_enter,
    input  logic                 take_short,
    input  logic                 take_long,
    input  bdlp_dbnc_t           enter_st,
    input  bdlp_dbnc_t           back_st,
    input  logic [31:0]          long_press_ms,
    output logic                 enter_pending,
    output logic                 short_pending,
    output logic                 long_pending
);

    // compare width covers both the timestamp and the hold register
    localparam int unsigned CW = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic                 enter_event_reg;
    logic                 short_event_reg;
    logic                 long_event_reg;
    logic                 long_fired_reg;
    logic [TIME_BITS-1:0] press_start_reg;

    logic                 back_fall;
    logic                 back_rise;
    logic                 fired_mid;
    logic [TIME_BITS-1:0] held;
    logic                 long_hit;
    logic                 enter_next;
    logic                 short_next;
    logic                 long_next;
    logic                 fired_next;

    // event decisions for this beat
    always_comb begin
        back_fall  = back_st.change & ~back_st.stable;
        back_rise  = back_st.change & back_st.stable;
        fired_mid  = back_fall ? 1'b0 : long_fired_reg;
        held       = back_fall ? '0 : (now - press_start_reg);
        long_hit   = ~back_st.stable & ~fired_mid & (CW'(held) >= CW'(long_press_ms));
        enter_next = (enter_event_reg & ~take_enter) | (enter_st.change & ~enter_st.stable);
        short_next = (short_event_reg & ~take_short) | (back_rise & ~long_fired_reg);
        long_next  = (long_event_reg & ~take_long) | long_hit;
        fired_next = fired_mid | long_hit;
    end

    assign enter_pending = enter_next;
    assign short_pending = short_next;
    assign long_pending  = long_next;

    // flag and press start registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enter_event_reg <= 1'b0;
            short_event_reg <= 1'b0;
            long_event_reg  <= 1'b0;
            long_fired_reg  <= 1'b0;
            press_start_reg <= '0;
        end else if (en) begin
            enter_event_reg <= enter_next;
            short_event_reg <= short_next;
            long_event_reg  <= long_next;
            long_fired_reg  <= fired_next;
            if (back_fall) begin
                press_start_reg <= now;
            end
        end
    end

    // flags only move on a processed beat
    a_flags_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(en) |-> ($stable(enter_event_reg) && $stable(short_event_reg)
                        && $stable(long_event_reg) && $stable(long_fired_reg)))
        else $error("event flags changed without a processed beat");

    // a long press event is always accompanied by the fired marker
    a_long_fired: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(long_event_reg) |-> long_fired_reg)
        else $error("long press latched without fired marker");

    // a short press never latches once the long press has fired
    a_short_no_long: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(short_event_reg) |-> !long_fired_reg)
        else $error("short press latched after long press fired");

endmodule

@@ src/button_debounce_long_press.sv @@
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Two-button debouncer: press event for the first button, short and long
// press events for the second, driven by timestamped level samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one sample beat: timestamp, two active-low
//   raw button levels and acknowledge bits that clear latched events.
//   m_valid/m_ready/m_data return one result beat per sample: the three
//   pending event flags and both debounced levels after the update.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write debounce_ms (index 0) and
//   long_press_ms (index 1); other indexes are ignored. Write only while
//   idle. cfg_ready is always high.
//   A sample accepted into the input register is loaded into the result
//   register when the result register can take a beat, and its result beat
//   is then offered on m_data. Throughput is one sample per cycle while
//   m_ready is high, with the subtract and compare update combinational
//   between the two registers.
//   Reset (aresetn low, synchronous) releases both buttons, clears all events
//   and times, and loads debounce_ms = 50 and long_press_ms = 5000.
//   When m_ready is low the result is held; the input register still takes
//   one more sample, then s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module button_debounce_long_press
    import bdlp_pkg::*;
#(
    parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  bdlp_in_t                s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output bdlp_out_t               m_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [31:0]             cfg_data
);

    logic [15:0]          debounce_ms_reg;
    logic [31:0]          long_press_ms_reg;
    logic                 in_valid_reg;
    bdlp_in_t             in_data_reg;
    logic                 out_valid_reg;
    bdlp_out_t            out_data_reg;

    logic                 advance;
    logic [TIME_BITS-1:0] now;
    bdlp_dbnc_t           enter_st;
    bdlp_dbnc_t           back_st;
    logic                 enter_pending;
    logic                 short_pending;
    logic                 long_pending;
    bdlp_out_t            result;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ms_reg   <= DEBOUNCE_MS_RST;
            long_press_ms_reg <= LONG_PRESS_MS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DEBOUNCE_MS:   debounce_ms_reg   <= cfg_data[15:0];
                CFG_LONG_PRESS_MS: long_press_ms_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // handshake: update runs when the result register can take a beat
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // timestamp taken modulo 2^TIME_BITS
    assign now = TIME_BITS'(in_data_reg.now_ms);

    bdlp_debounce #(
        .TIME_BITS (TIME_BITS)
    ) u_enter_dbnc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .raw         (in_data_reg.enter_level),
        .now         (now),
        .debounce_ms (debounce_ms_reg),
        .status      (enter_st)
    );

    bdlp_debounce #(
        .TIME_BITS (TIME_BITS)
    ) u_back_dbnc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .raw         (in_data_reg.back_level),
        .now         (now),
        .debounce_ms (debounce_ms_reg),
        .status      (back_st)
    );

    bdlp_events #(
        .TIME_BITS (TIME_BITS)
    ) u_events (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (advance),
        .now           (now),
        .take_enter    (in_data_reg.take_enter),
        .take_short    (in_data_reg.take_short),
        .take_long     (in_data_reg.take_long),
        .enter_st      (enter_st),
        .back_st       (back_st),
        .long_press_ms (long_press_ms_reg),
        .enter_pending (enter_pending),
        .short_pending (short_pending),
        .long_pending  (long_pending)
    );

    // result beat in field order
    assign result = {enter_pending, short_pending, long_pending,
                     enter_st.stable, back_st.stable};

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for button_debounce_long_press. A directed table of
// button sequences runs first, then random press timelines under several
// register settings. Both channels idle and stall at random. Each result beat
// is compared field by field with the in-bench debouncer model or a pinned result.
// ----------------------------------------------------------------------------
module tb_top;
    import bdlp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int unsigned PHASE_ITEMS  = 125;
    localparam int unsigned NUM_PHASES   = 6;
    localparam int unsigned CALM_PHASE   = 3;
    localparam int unsigned SPARE_PHASE  = 4;
    localparam int unsigned IDLE_PCT     = 27;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_PRINTS   = 30;
    localparam int unsigned PLAN_LEN     = 25;

    // index that maps to no register
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = CFG_IDX_BITS'(200);

    // acknowledge bits in beat order: take_enter, take_short, take_long
    localparam logic [2:0] ACK_NONE  = 3'b000;
    localparam logic [2:0] ACK_ENTER = 3'b100;
    localparam logic [2:0] ACK_SHORT = 3'b010;
    localparam logic [2:0] ACK_LONG  = 3'b001;
    localparam logic [2:0] ACK_ALL   = 3'b111;

    // register settings per random phase, extremes included
    localparam logic [15:0] PHASE_DEB [NUM_PHASES] =
        '{16'd50, 16'd0, 16'hFFFF, 16'd3, 16'd20, 16'd7};
    localparam logic [31:0] PHASE_LONG [NUM_PHASES] =
        '{32'd5000, 32'd0, 32'hFFFF_FFFF, 32'd40, 32'd300, 32'd1};

    // one directed sample; res is {enter, short, long, enter_st, back_st}
    typedef struct packed {
        logic [31:0] now;
        logic        enter;
        logic        back;
        logic [2:0]  ack;
        logic        pinned;
        logic [4:0]  res;
    } plan_row_t;

    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // quiet start after reset
        '{32'd0,          1'b1, 1'b1, ACK_NONE,  1'b1, 5'b00011},
        // first button: debounce window edge, stable fall, acknowledge
        '{32'd10,         1'b0, 1'b1, ACK_NONE,  1'b0, 5'b00000},
        '{32'd60,         1'b0, 1'b1, ACK_NONE,  1'b0, 5'b00000},
        '{32'd61,         1'b0, 1'b1, ACK_NONE,  1'b0, 5'b00000},
        '{32'd70,         1'b0, 1'b1, ACK_ENTER, 1'b0, 5'b00000},
        // second button held into a long press, release gives no short press
        '{32'd100,        1'b1, 1'b0, ACK_NONE,  1'b0, 5'b00000},
        '{32'd151,        1'b1, 1'b0, ACK_NONE,  1'b0, 5'b00000},
        '{32'd5150,       1'b1, 1'b0, ACK_NONE,  1'b0, 5'b00000},
        '{32'd5151,       1'b1, 1'b0, ACK_NONE,  1'b0, 5'b00000},
        '{32'd5200,       1'b1, 1'b1, ACK_NONE,  1'b0, 5'b00000},
        '{32'd5251,       1'b1, 1'b1, ACK_NONE,  1'b0, 5'b00000},
        '{32'd5260,       1'b1, 1'b1, ACK_LONG,  1'b0, 5'b00000},
        // short press, acknowledged in the same update that latches it
        '{32'd6000,       1'b1, 1'b0, ACK_NONE,  1'b0, 5'b00000},
        '{32'd6051,       1'b1, 1'b0, ACK_NONE,  1'b0, 5'b00000},
        '{32'd6100,       1'b1, 1'b1, ACK_NONE,  1'b0, 5'b00000},
        '{32'd6151,       1'b1, 1'b1, ACK_SHORT, 1'b0, 5'b00000},
        // clear-all request
        '{32'd6160,       1'b1, 1'b1, ACK_ALL,   1'b1, 5'b00011},
        // timestamp wraps through zero
        '{32'hFFFF_FFE0,  1'b0, 1'b1, ACK_NONE,  1'b0, 5'b00000},
        '{32'h0000_0012,  1'b0, 1'b1, ACK_NONE,  1'b0, 5'b00000},
        '{32'h0000_0013,  1'b0, 1'b1, ACK_NONE,  1'b0, 5'b00000},
        // timestamp going backwards
        '{32'h0000_1000,  1'b1, 1'b1, ACK_NONE,  1'b0, 5'b00000},
        '{32'h0000_0FFF,  1'b1, 1'b1, ACK_NONE,  1'b0, 5'b00000},
        // both pressed at the top of the range, long press across bit 31
        '{32'hFFFF_FFFF,  1'b0, 1'b0, ACK_ALL,   1'b0, 5'b00000},
        '{32'h7FFF_FFFF,  1'b0, 1'b0, ACK_NONE,  1'b0, 5'b00000},
        '{32'h8000_1387,  1'b0, 1'b0, ACK_NONE,  1'b0, 5'b00000}
    };

    // debouncer state of one button
    typedef struct packed {
        logic        raw_prev;
        logic        stable;
        logic [31:0] changed_at;
    } btn_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    bdlp_in_t                s_data;
    logic                    m_valid;
    logic                    m_ready;
    bdlp_out_t               m_data;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [31:0]             cfg_data;

    // model of the block: registers and button state
    logic [15:0] deb_ms;
    logic [31:0] long_ms;
    btn_t        enter_btn;
    btn_t        back_btn;
    logic [31:0] press_start;
    logic        enter_evt;
    logic        short_evt;
    logic        long_evt;
    logic        long_fired;

    bdlp_out_t   pending_results [$];

    // directed rows with a typed-in result
    logic        pin_on;
    bdlp_out_t   pin_res;

    // random timeline
    logic [31:0] gen_ms;
    logic        gen_enter;
    logic        gen_back;
    logic        calm;

    int unsigned errors        = 0;
    int unsigned beats_checked = 0;
    int unsigned samples_taken = 0;
    int unsigned short_seen    = 0;
    int unsigned long_seen     = 0;
    int unsigned cycle_count   = 0;

    button_debounce_long_press u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result sink with random stalls
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic got, input logic want);
        if (got !== want)
            report_mismatch($sformatf("result beat %0d: %s is %b, expected %b",
                                      beats_checked, name, got, want));
    endtask

    // one debounce update; flipped is set when the stable level moves
    function automatic btn_t settle_button(input btn_t b, input logic raw,
                                           input logic [31:0] now,
                                           output logic flipped);
        logic [31:0] held;
        flipped = 1'b0;
        if (raw != b.raw_prev) begin
            b.changed_at = now;
            b.raw_prev   = raw;
        end
        held = now - b.changed_at;
        if (held > {16'd0, deb_ms} && raw != b.stable) begin
            b.stable = raw;
            flipped  = 1'b1;
        end
        return b;
    endfunction

    // advance the model by one sample beat and return the flags after it
    function automatic bdlp_out_t update_buttons(input bdlp_in_t smp);
        logic enter_flip;
        logic back_flip;
        if (smp.take_enter) enter_evt = 1'b0;
        if (smp.take_short) short_evt = 1'b0;
        if (smp.take_long)  long_evt  = 1'b0;

        enter_btn = settle_button(enter_btn, smp.enter_level, smp.now_ms, enter_flip);
        if (enter_flip && !enter_btn.stable)
            enter_evt = 1'b1;

        back_btn = settle_button(back_btn, smp.back_level, smp.now_ms, back_flip);
        if (back_flip && !back_btn.stable) begin
            press_start = smp.now_ms;
            long_fired  = 1'b0;
        end else if (back_flip && !long_fired) begin
            short_evt = 1'b1;
        end

        // hold time of the second button
        if (!back_btn.stable && !long_fired && (smp.now_ms - press_start) >= long_ms) begin
            long_evt   = 1'b1;
            long_fired = 1'b1;
        end
        return {enter_evt, short_evt, long_evt, enter_btn.stable, back_btn.stable};
    endfunction

    // register writes, result compare and model update, in edge order
    always @(posedge aclk) begin : result_compare
        bdlp_out_t want;
        if (!aresetn) begin
            deb_ms      = DEBOUNCE_MS_RST;
            long_ms     = LONG_PRESS_MS_RST;
            enter_btn   = {1'b1, 1'b1, 32'd0};
            back_btn    = {1'b1, 1'b1, 32'd0};
            press_start = '0;
            enter_evt   = 1'b0;
            short_evt   = 1'b0;
            long_evt    = 1'b0;
            long_fired  = 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DEBOUNCE_MS:   deb_ms  = cfg_data[15:0];
                    CFG_LONG_PRESS_MS: long_ms = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                beats_checked++;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d arrived with none expected",
                                              beats_checked));
                end else begin
                    want = pending_results.pop_front();
                    check_field("enter_pending", m_data.enter_pending, want.enter_pending);
                    check_field("short_pending", m_data.short_pending, want.short_pending);
                    check_field("long_pending", m_data.long_pending, want.long_pending);
                    check_field("enter_stable_level", m_data.enter_stable_level,
                                want.enter_stable_level);
                    check_field("back_stable_level", m_data.back_stable_level,
                                want.back_stable_level);
                    short_seen += want.short_pending;
                    long_seen  += want.long_pending;
                end
            end
            if (s_valid && s_ready) begin
                samples_taken++;
                want = update_buttons(s_data);
                pending_results.push_back(pin_on ? pin_res : want);
            end
        end
    end

    // present one sample beat, called and returning at a falling edge
    task automatic send_sample(input bdlp_in_t smp);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_data  = smp;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // all results back, then the pipeline latency on top
    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // next point of a random press timeline: mostly holds and bounces
    // around the debounce time, some long holds, some jumps and steps back
    function automatic bdlp_in_t random_sample();
        int unsigned pick;
        logic [2:0]  ack;
        pick = $urandom_range(99);
        if (pick < 65)
            gen_ms += $urandom_range(deb_ms / 4 + 4);
        else if (pick < 82)
            gen_ms += deb_ms + $urandom_range(1, 3);
        else if (pick < 92)
            gen_ms += long_ms + $urandom_range(2) - 1;
        else if (pick < 97)
            gen_ms = $urandom();
        else
            gen_ms -= 1;
        if ($urandom_range(99) < 22) gen_enter = ~gen_enter;
        if ($urandom_range(99) < 22) gen_back  = ~gen_back;
        ack = {$urandom_range(99) < 15, $urandom_range(99) < 12, $urandom_range(99) < 12};
        return {gen_ms, gen_enter, gen_back, ack};
    endfunction

    // stimulus
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        pin_on    = 1'b0;
        pin_res   = '0;
        calm      = 1'b0;
        gen_ms    = '0;
        gen_enter = 1'b1;
        gen_back  = 1'b1;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed button sequences
        foreach (PLAN[i]) begin
            pin_on  = PLAN[i].pinned;
            pin_res = bdlp_out_t'(PLAN[i].res);
            send_sample({PLAN[i].now, PLAN[i].enter, PLAN[i].back, PLAN[i].ack});
        end
        pin_on  = 1'b0;
        s_valid = 1'b0;
        gen_ms  = 32'h8000_2000;

        // random timelines, one register setting per phase
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_reg(CFG_DEBOUNCE_MS, {16'($urandom()), PHASE_DEB[p]});
            if (p == SPARE_PHASE)
                write_reg(CFG_SPARE, $urandom());
            write_reg(CFG_LONG_PRESS_MS, PHASE_LONG[p]);
            calm = (p == CALM_PHASE);
            repeat (PHASE_ITEMS) send_sample(random_sample());
            s_valid = 1'b0;
        end
        calm = 1'b0;
        wait_drained();

        $display("ran %0d sample beats: %0d directed, the rest random over %0d settings",
                 samples_taken, PLAN_LEN, NUM_PHASES);
        $display("checked %0d result beats, %0d with short press and %0d with long press",
                 beats_checked, short_seen, long_seen);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/bdlp_pkg.sv
src/bdlp_debounce.sv
src/bdlp_events.sv
src/button_debounce_long_press.sv
tb/sv/tb_top.sv
